### design/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Register map indexes and sizing helpers shared by the design and checker.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // Configuration register indexes (one address bit selects the register).
    localparam logic REG_EXPONENT = 1'b0;
    localparam logic REG_MODULUS  = 1'b1;

    // Width of a field group rounded up to whole bytes.
    function automatic int byte_pad(input int bits);
        byte_pad = ((bits + 7) / 8) * 8;
    endfunction

endpackage

### design/mexp_mulser.sv
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Forms (a * b) mod m by shift-and-add, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module mexp_mulser #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] a_in,
    input  logic [VALUE_WIDTH-1:0] b_in,
    input  logic [VALUE_WIDTH-1:0] mod_in,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] product
);

    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     a_reg, a_next;
    logic [W-1:0]     b_shift_reg, b_shift_next;
    logic [W-1:0]     acc_reg, acc_next;

    logic [W+1:0]     sum;
    logic [W+2:0]     diff1;
    logic [W+2:0]     diff2;
    logic [W-1:0]     step_val;

    // The doubled accumulator plus the optional addend stays below 3m, so one
    // subtraction of m or 2m brings it back into range.
    always_comb begin
        sum   = {1'b0, acc_reg, 1'b0} + (b_shift_reg[W-1] ? {2'b00, a_reg} : '0);
        diff1 = {1'b0, sum} - {3'b000, mod_in};
        diff2 = {1'b0, sum} - {2'b00, mod_in, 1'b0};
        if (!diff2[W+2]) begin
            step_val = diff2[W-1:0];
        end else if (!diff1[W+2]) begin
            step_val = diff1[W-1:0];
        end else begin
            step_val = sum[W-1:0];
        end
    end

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        a_next       = a_reg;
        b_shift_next = b_shift_reg;
        acc_next     = acc_reg;
        if (start) begin
            busy_next    = 1'b1;
            cnt_next     = CNT_W'(W - 1);
            a_next       = a_in;
            b_shift_next = b_in;
            acc_next     = '0;
        end else if (busy_reg) begin
            acc_next     = step_val;
            b_shift_next = {b_shift_reg[W-2:0], 1'b0};
            cnt_next     = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        a_reg       <= a_next;
        b_shift_reg <= b_shift_next;
        acc_reg     <= acc_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### design/mexp_seq.sv
// ----------------------------------------------------------------------------
// Exponentiation sequencer
// Left-to-right square-and-multiply over a shifting exponent, driving the
// serial multiplier, with a result register toward the output stream.
// ----------------------------------------------------------------------------
module mexp_seq #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [VALUE_WIDTH-1:0] base_value,
    input  logic [VALUE_WIDTH-1:0] key_exponent,
    input  logic [VALUE_WIDTH-1:0] key_modulus,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VALUE_WIDTH-1:0] power_result,
    output logic                   modulus_error
);

    localparam int W     = VALUE_WIDTH;
    localparam int CNT_W = $clog2(W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_SQUARE,
        S_MULT,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [W-1:0]     exp_shift_reg, exp_shift_next;
    logic [CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [W-1:0]     base_reg, base_next;
    logic [W-1:0]     acc_reg, acc_next;
    logic             err_reg, err_next;
    logic             start_reg, start_next;
    logic [W-1:0]     op_a_reg, op_a_next;
    logic [W-1:0]     op_b_reg, op_b_next;
    logic             out_valid_reg, out_valid_next;
    logic [W-1:0]     out_data_reg, out_data_next;
    logic             out_err_reg, out_err_next;

    logic             mul_done;
    logic [W-1:0]     mul_product;
    logic [W-1:0]     one_mod;
    logic             out_free;

    // 1 mod m: zero when the modulus is one.
    assign one_mod  = (key_modulus == W'(1)) ? '0 : W'(1);
    assign out_free = !out_valid_reg || out_ready;

    mexp_mulser #(
        .VALUE_WIDTH(W)
    ) u_mulser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .a_in    (op_a_reg),
        .b_in    (op_b_reg),
        .mod_in  (key_modulus),
        .done    (mul_done),
        .product (mul_product)
    );

    always_comb begin
        state_next     = state_reg;
        exp_shift_next = exp_shift_reg;
        bit_cnt_next   = bit_cnt_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        err_next       = err_reg;
        start_next     = 1'b0;
        op_a_next      = op_a_reg;
        op_b_next      = op_b_reg;
        out_data_next  = out_data_reg;
        out_err_next   = out_err_reg;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    exp_shift_next = key_exponent;
                    bit_cnt_next   = CNT_W'(W - 1);
                    err_next       = 1'b0;
                    if (key_modulus == '0) begin
                        acc_next   = '0;
                        err_next   = 1'b1;
                        state_next = S_FINISH;
                    end else if (key_exponent == '0) begin
                        acc_next   = W'(1);
                        state_next = S_FINISH;
                    end else begin
                        // Reduce the base by multiplying it with 1 mod m.
                        acc_next   = one_mod;
                        op_a_next  = one_mod;
                        op_b_next  = base_value;
                        start_next = 1'b1;
                        state_next = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (mul_done) begin
                    base_next  = mul_product;
                    op_a_next  = acc_reg;
                    op_b_next  = acc_reg;
                    start_next = 1'b1;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE, S_MULT: begin
                if (mul_done) begin
                    acc_next = mul_product;
                    if (state_reg == S_SQUARE && exp_shift_reg[W-1]) begin
                        op_a_next  = mul_product;
                        op_b_next  = base_reg;
                        start_next = 1'b1;
                        state_next = S_MULT;
                    end else begin
                        exp_shift_next = {exp_shift_reg[W-2:0], 1'b0};
                        if (bit_cnt_reg == '0) begin
                            state_next = S_FINISH;
                        end else begin
                            bit_cnt_next = bit_cnt_reg - CNT_W'(1);
                            op_a_next    = mul_product;
                            op_b_next    = mul_product;
                            start_next   = 1'b1;
                            state_next   = S_SQUARE;
                        end
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    out_data_next  = acc_reg;
                    out_err_next   = err_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        exp_shift_reg <= exp_shift_next;
        bit_cnt_reg   <= bit_cnt_next;
        base_reg      <= base_next;
        acc_reg       <= acc_next;
        err_reg       <= err_next;
        op_a_reg      <= op_a_next;
        op_b_reg      <= op_b_next;
        out_data_reg  <= out_data_next;
        out_err_reg   <= out_err_next;
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign power_result  = out_data_reg;
    assign modulus_error = out_err_reg;

endmodule

### design/modular_exponentiation.sv
// A zero modulus or exponent skips the multiplier and goes to the result register;
// else the serial multiplier forms a base reduction, a square per exponent bit
// and a multiply per set bit, for one item at a time.
// The result register lets the next item start while one waits.
// Reset (synchronous, active low) idles the block and sets both keys to 1.
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Stream in a base, stream out base^exponent mod modulus; keys via APB port.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    // s_tdata: base_value
    input  logic [mexp_pkg::byte_pad(VALUE_WIDTH)-1:0]     s_tdata,
    input  logic                                            s_tvalid,
    output logic                                            s_tready,
    // m_tdata: power_result, modulus_error
    output logic [mexp_pkg::byte_pad(VALUE_WIDTH + 1)-1:0] m_tdata,
    output logic                                            m_tvalid,
    input  logic                                            m_tready,
    input  logic                                            psel,
    input  logic                                            penable,
    input  logic                                            pwrite,
    input  logic [((VALUE_WIDTH > 32) ? 4 : 3)-1:0]         paddr,
    input  logic [((VALUE_WIDTH > 32) ? 64 : 32)-1:0]       pwdata,
    output logic [((VALUE_WIDTH > 32) ? 64 : 32)-1:0]       prdata,
    output logic                                            pready
);

    localparam int W      = VALUE_WIDTH;
    localparam int ADDR_W = (W > 32) ? 4 : 3;
    localparam int DATA_W = (W > 32) ? 64 : 32;
    localparam int OUT_W  = mexp_pkg::byte_pad(W + 1);

    logic [W-1:0] exponent_reg, exponent_next;
    logic [W-1:0] modulus_reg, modulus_next;
    logic         reg_sel;
    logic         cfg_write;
    logic [W-1:0] power_result;
    logic         modulus_error;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[ADDR_W-1];
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        exponent_next = exponent_reg;
        modulus_next  = modulus_reg;
        if (cfg_write) begin
            unique case (reg_sel)
                mexp_pkg::REG_EXPONENT: exponent_next = pwdata[W-1:0];
                mexp_pkg::REG_MODULUS:  modulus_next  = pwdata[W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            mexp_pkg::REG_EXPONENT: prdata = DATA_W'(exponent_reg);
            mexp_pkg::REG_MODULUS:  prdata = DATA_W'(modulus_reg);
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exponent_reg <= W'(1);
            modulus_reg  <= W'(1);
        end else begin
            exponent_reg <= exponent_next;
            modulus_reg  <= modulus_next;
        end
    end

    mexp_seq #(
        .VALUE_WIDTH(W)
    ) u_seq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .base_value    (s_tdata[W-1:0]),
        .key_exponent  (exponent_reg),
        .key_modulus   (modulus_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .power_result  (power_result),
        .modulus_error (modulus_error)
    );

    assign m_tdata = OUT_W'({modulus_error, power_result});

endmodule

### design/mexp_checker.sv
// ----------------------------------------------------------------------------
// Modular exponentiation port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module mexp_port_checker #(
    parameter int VALUE_WIDTH = 16
) (
    input logic                                            aclk,
    input logic                                            aresetn,
    input logic                                            s_tvalid,
    input logic                                            s_tready,
    input logic [mexp_pkg::byte_pad(VALUE_WIDTH + 1)-1:0] m_tdata,
    input logic                                            m_tvalid,
    input logic                                            m_tready,
    input logic                                            psel,
    input logic                                            penable,
    input logic                                            pwrite,
    input logic [((VALUE_WIDTH > 32) ? 4 : 3)-1:0]         paddr,
    input logic [((VALUE_WIDTH > 32) ? 64 : 32)-1:0]       pwdata,
    input logic [((VALUE_WIDTH > 32) ? 64 : 32)-1:0]       prdata,
    input logic                                            pready
);

    localparam int W = VALUE_WIDTH;

    // A stalled result holds its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in work");

    // An invalid modulus always comes with a zero result.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[W] |-> m_tdata[W-1:0] == '0)
        else $error("modulus error with nonzero result");

    // A register reads back what was just written to it.
    a_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && pready)
        ##1 (aresetn && psel && !penable && !pwrite && paddr == $past(paddr))
        ##1 (psel && penable && !pwrite && paddr == $past(paddr))
        |-> prdata[W-1:0] == $past(pwdata[W-1:0], 2))
        else $error("register readback mismatch");

endmodule

bind modular_exponentiation mexp_port_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_mexp_checker (.*);

### bench/mexp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Watches the key port and both streams, predicts base^exponent mod modulus
// for every accepted base and compares each result item with the oldest
// prediction.
// ----------------------------------------------------------------------------
module mexp_checker #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic [mexp_pkg::byte_pad(VALUE_WIDTH)-1:0]     s_tdata,
    input  logic                                            s_tvalid,
    input  logic                                            s_tready,
    input  logic [mexp_pkg::byte_pad(VALUE_WIDTH + 1)-1:0] m_tdata,
    input  logic                                            m_tvalid,
    input  logic                                            m_tready,
    input  logic                                            psel,
    input  logic                                            penable,
    input  logic                                            pwrite,
    input  logic [((VALUE_WIDTH > 32) ? 4 : 3)-1:0]         paddr,
    input  logic [((VALUE_WIDTH > 32) ? 64 : 32)-1:0]       pwdata,
    input  logic                                            pready,
    output int                                              fail_count,
    output int                                              pending_count,
    output int                                              result_count
);

    localparam int VW = VALUE_WIDTH;
    localparam int PA = (VALUE_WIDTH > 32) ? 4 : 3;

    typedef logic [VW-1:0] value_t;

    typedef struct packed {
        value_t power;
        logic   error;
    } power_result_t;

    value_t        exponent_key;
    value_t        modulus_key;
    power_result_t expected_powers[$];
    power_result_t predicted;
    power_result_t oldest;
    power_result_t observed;
    int            mismatches;
    int            results_seen;

    function automatic value_t mul_mod(input value_t a, input value_t b, input value_t m);
        logic [2*VW-1:0] product;
        product = {{VW{1'b0}}, a} * {{VW{1'b0}}, b};
        return value_t'(product % {{VW{1'b0}}, m});
    endfunction

    // Left-to-right square-and-multiply over every exponent bit.
    function automatic power_result_t predict_power(input value_t base, input value_t e,
                                                    input value_t m);
        power_result_t r;
        value_t        b;
        value_t        acc;
        r.error = 1'b0;
        if (m == '0) begin
            r.power = '0;
            r.error = 1'b1;
        end else if (e == '0) begin
            r.power = value_t'(1);
        end else begin
            b   = base % m;
            acc = value_t'(1) % m;
            for (int i = VW - 1; i >= 0; i--) begin
                acc = mul_mod(acc, acc, m);
                if (e[i]) begin
                    acc = mul_mod(acc, b, m);
                end
            end
            r.power = acc;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            exponent_key = value_t'(1);
            modulus_key  = value_t'(1);
            expected_powers.delete();
            mismatches   = 0;
            results_seen = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predicted = predict_power(s_tdata[VW-1:0], exponent_key, modulus_key);
                expected_powers.push_back(predicted);
            end
            if (m_tvalid && m_tready) begin
                observed.power = m_tdata[VW-1:0];
                observed.error = m_tdata[VW];
                results_seen++;
                if (expected_powers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected result item power=%h error=%b",
                                 $realtime, observed.power, observed.error);
                    end
                end else begin
                    oldest = expected_powers.pop_front();
                    if (observed.power !== oldest.power || observed.error !== oldest.error) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: result %0d power exp=%h act=%h, error exp=%b act=%b",
                                     $realtime, results_seen, oldest.power, observed.power,
                                     oldest.error, observed.error);
                        end
                    end
                end
            end
            // Keys change only while the streams are idle, so order within this edge is free.
            if (psel && penable && pwrite && pready) begin
                if (paddr[PA-1] == mexp_pkg::REG_MODULUS) begin
                    modulus_key = pwdata[VW-1:0];
                end else begin
                    exponent_key = pwdata[VW-1:0];
                end
            end
        end
        fail_count    <= mismatches;
        pending_count <= expected_powers.size();
        result_count  <= results_seen;
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Loads a series of key settings over the register port, streams bases
// through the block with random gaps and back-pressure, and reports the
// verdict kept by the checker.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int VW = 16;
    localparam int DW = mexp_pkg::byte_pad(VW);
    localparam int RW = mexp_pkg::byte_pad(VW + 1);
    localparam int PA = (VW > 32) ? 4 : 3;
    localparam int PD = (VW > 32) ? 64 : 32;
    localparam int PHASES = 12;
    localparam int ITEMS_PER_PHASE = 80;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic [DW-1:0] s_tdata = '0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [RW-1:0] m_tdata;
    logic          m_tvalid;
    logic          m_tready = 1'b1;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [PA-1:0] paddr = '0;
    logic [PD-1:0] pwdata = '0;
    logic [PD-1:0] prdata;
    logic          pready;

    int fail_count;
    int pending_count;
    int result_count;
    int bases_sent = 0;
    int settings_used = 0;
    int send_gap_level = 1;
    int stall_level = 1;
    int stall_left = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    modular_exponentiation #(
        .VALUE_WIDTH(VW)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    mexp_checker #(
        .VALUE_WIDTH(VW)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tdata       (s_tdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .m_tdata       (m_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    // Result back-pressure: ready runs of random length broken by stalls of random length.
    always @(posedge aclk) begin
        if (stall_level == 0) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (m_tready && $urandom_range(0, 3) < stall_level) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 12);
        end else begin
            m_tready   <= 1'b1;
            stall_left <= $urandom_range(0, 20);
        end
    end

    task automatic write_key(input logic reg_sel, input logic [PD-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, {(PA-1){1'b0}}};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Keys are only changed once every outstanding result has been returned.
    task automatic load_keys(input logic [VW-1:0] e, input logic [VW-1:0] m,
                             input logic [PD-1:0] junk);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) begin
            @(posedge aclk);
        end
        write_key(mexp_pkg::REG_EXPONENT, {junk[PD-1:VW], e});
        write_key(mexp_pkg::REG_MODULUS, {junk[PD-1:VW], m});
        settings_used++;
    endtask

    task automatic send_base(input logic [VW-1:0] base);
        s_tdata  <= DW'(base);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        bases_sent++;
        if (send_gap_level != 0 && $urandom_range(0, 3) < send_gap_level) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    initial begin
        logic [VW-1:0] exp_pick;
        logic [VW-1:0] mod_pick;
        logic [VW-1:0] base_pick;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Keys as left by reset: exponent 1, modulus 1.
        send_base('0);
        send_base('1);

        // Zero exponent gives 1, also with a modulus of 1.
        load_keys('0, VW'(1), '0);
        send_base(VW'(5));
        send_base('1);

        // Zero modulus flags an error whatever the exponent.
        load_keys('0, '0, '0);
        send_base(VW'(7));
        load_keys('1, '0, '0);
        send_base('1);
        send_base('0);

        // Largest exponent and modulus; the all-ones base reduces to zero first.
        load_keys('1, '1, '1);
        send_base('0);
        send_base(VW'(1));
        send_base('1);
        send_base('1 - VW'(1));
        send_base(VW'(1) << (VW - 1));

        // Textbook key pair with modulus 3233: encrypt, then a base above the modulus.
        load_keys(VW'(17), VW'(3233), '0);
        send_base(VW'(65));
        send_base(VW'(3233 + 65));
        load_keys(VW'(2753), VW'(3233), '0);
        send_base(VW'(2790));

        load_keys(VW'(1), '1, '0);
        send_base('1);
        send_base(VW'(12345));
        load_keys(VW'(2), VW'(2), '0);
        send_base(VW'(3));
        send_base(VW'(2));

        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0:       exp_pick = '0;
                1:       exp_pick = '1;
                2, 3:    exp_pick = VW'($urandom_range(1, 255));
                default: exp_pick = VW'($urandom());
            endcase
            case ($urandom_range(0, 7))
                0:       mod_pick = '0;
                1:       mod_pick = VW'(1);
                2:       mod_pick = '1;
                3:       mod_pick = VW'($urandom_range(2, 255));
                default: mod_pick = VW'($urandom());
            endcase
            if (ph == PHASES - 1) begin
                send_gap_level = 0;
                stall_level    = 0;
            end else begin
                send_gap_level = $urandom_range(0, 3);
                stall_level    = $urandom_range(0, 3);
            end
            load_keys(exp_pick, mod_pick, PD'({$urandom(), $urandom()}));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                case ($urandom_range(0, 9))
                    0:       base_pick = '0;
                    1:       base_pick = '1;
                    2, 3:    base_pick = (mod_pick == '0) ? VW'($urandom()) :
                                         VW'($urandom()) % mod_pick;
                    default: base_pick = VW'($urandom());
                endcase
                send_base(base_pick);
                // Midway through one phase the sender waits for the block to drain.
                if (ph == 3 && n == ITEMS_PER_PHASE / 2) begin
                    s_tvalid <= 1'b0;
                    @(posedge aclk);
                    while (pending_count != 0) begin
                        @(posedge aclk);
                    end
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) begin
            @(posedge aclk);
        end
        repeat (700) @(posedge aclk);

        $display("Checked %0d results for %0d bases over %0d key settings,", result_count,
                 bases_sent, settings_used);
        $display("including zero modulus, zero exponent and full-width keys.");
        if (fail_count == 0 && pending_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #50000000;
        $display("Timed out with %0d results still expected.", pending_count);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
